// ===== src/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cram_pkg
// types and constants shared by the i2c register access master
// ----------------------------------------------------------------------------
package i2cram_pkg;

	localparam int unsigned DevAddrW = 7;
	localparam logic [DevAddrW-1:0] DEV_ADDR_RESET = 7'd104;

	// command codes carried by op
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic RW_WRITE = 1'b0;
	localparam logic RW_READ  = 1'b1;
	localparam logic [7:0] MSB_MASK = 8'h80;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_W_START   = 4'd1,
		PH_W_ADDR    = 4'd2,
		PH_W_REG     = 4'd3,
		PH_W_VAL     = 4'd4,
		PH_R_START   = 4'd5,
		PH_R_ADDRW   = 4'd6,
		PH_R_REG     = 4'd7,
		PH_R_RESTART = 4'd8,
		PH_R_ADDRR   = 4'd9,
		PH_R_READ    = 4'd10,
		PH_STOP      = 4'd11
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] reg_addr;
		logic [7:0] write_value;
		logic [7:0] read_length;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic       success;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] step;
		logic [2:0] bit_pos;
		logic [7:0] shift;
		logic [7:0] remaining;
		logic [7:0] held_reg;
		logic [7:0] held_val;
		logic       clk_level;
		logic       dat_level;
		logic       acked;
	} seq_state_t;

endpackage

// ===== src/i2cram_seq.sv =====
// ----------------------------------------------------------------------------
// i2cram_seq
// bus sequencer: state registers and the one-word next-state logic
// ----------------------------------------------------------------------------
module i2cram_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [i2cram_pkg::DevAddrW-1:0]    cfg_wr_data,
	input  logic                               step_en,
	input  i2cram_pkg::item_t                  item,
	output i2cram_pkg::result_t                result
);
	import i2cram_pkg::*;

	seq_state_t             st_q;
	seq_state_t             nx;
	logic [DevAddrW-1:0]    dev_addr_q;
	logic [7:0]             addr_w;
	logic [7:0]             bit_mask;
	logic [7:0]             rx_shift;
	logic                   fin;

	assign addr_w   = {dev_addr_q, RW_WRITE};
	assign bit_mask = MSB_MASK >> st_q.bit_pos;
	assign rx_shift = item.sda_in ? (st_q.shift | bit_mask) : st_q.shift;

	always_comb begin
		nx     = st_q;
		fin    = 1'b0;
		result = '0;
		result.busy_res = (st_q.phase != PH_IDLE);

		if (st_q.phase == PH_IDLE) begin
			if (item.op == OP_WRITE || item.op == OP_READ) begin
				nx.held_reg  = item.reg_addr;
				nx.held_val  = item.write_value;
				nx.remaining = item.read_length;
				nx.acked     = 1'b0;
				nx.phase     = (item.op == OP_WRITE) ? PH_W_START : PH_R_START;
				nx.step      = '0;
				nx.bit_pos   = '0;
				result.busy_res = 1'b1;
			end
		end else if (item.op == OP_TICK) begin
			case (st_q.phase)
				PH_W_START, PH_R_START, PH_R_RESTART: begin
					case (st_q.step)
						3'd0: begin
							nx.dat_level = 1'b1;
							nx.step = 3'd1;
						end
						3'd1: begin
							nx.clk_level = 1'b1;
							nx.step = 3'd2;
						end
						3'd2: begin
							nx.dat_level = 1'b0;
							nx.step = 3'd3;
						end
						default: begin
							nx.clk_level = 1'b0;
							nx.step    = '0;
							nx.bit_pos = '0;
							case (st_q.phase)
								PH_W_START: begin
									nx.phase = PH_W_ADDR;
									nx.shift = addr_w;
								end
								PH_R_START: begin
									nx.phase = PH_R_ADDRW;
									nx.shift = addr_w;
								end
								default: begin
									nx.phase = PH_R_ADDRR;
									nx.shift = {dev_addr_q, RW_READ};
								end
							endcase
						end
					endcase
				end
				PH_W_ADDR, PH_W_REG, PH_W_VAL, PH_R_ADDRW, PH_R_REG, PH_R_ADDRR: begin
					case (st_q.step)
						3'd0: begin
							nx.dat_level = |(st_q.shift & bit_mask);
							nx.step = 3'd1;
						end
						3'd1: begin
							nx.clk_level = 1'b1;
							nx.step = 3'd2;
						end
						3'd2: begin
							nx.clk_level = 1'b0;
							if (st_q.bit_pos == 3'd7) begin
								nx.step = 3'd3;
							end else begin
								nx.bit_pos = st_q.bit_pos + 3'd1;
								nx.step = 3'd0;
							end
						end
						3'd3: begin
							nx.dat_level = 1'b1;
							nx.step = 3'd4;
						end
						3'd4: begin
							nx.clk_level = 1'b1;
							nx.step = 3'd5;
						end
						3'd5: begin
							nx.acked = ~item.sda_in;
							nx.step = 3'd6;
						end
						3'd6: begin
							nx.clk_level = 1'b0;
							nx.step = '0;
							fin = 1'b1;
						end
						default: begin
							nx.step = '0;
						end
					endcase
					if (fin) begin
						nx.bit_pos = '0;
						// nack in the slot aborts to stop
						if (!st_q.acked) begin
							nx.phase = PH_STOP;
						end else begin
							case (st_q.phase)
								PH_W_ADDR: begin
									nx.phase = PH_W_REG;
									nx.shift = st_q.held_reg;
								end
								PH_W_REG: begin
									nx.phase = PH_W_VAL;
									nx.shift = st_q.held_val;
								end
								PH_R_ADDRW: begin
									nx.phase = PH_R_REG;
									nx.shift = st_q.held_reg;
								end
								PH_R_REG: nx.phase = PH_R_RESTART;
								PH_R_ADDRR: begin
									nx.phase = (st_q.remaining != 8'd0) ? PH_R_READ : PH_STOP;
								end
								default: nx.phase = PH_STOP;
							endcase
						end
					end
				end
				PH_R_READ: begin
					case (st_q.step)
						3'd0: begin
							nx.dat_level = 1'b1;
							nx.shift   = '0;
							nx.bit_pos = '0;
							nx.step    = 3'd1;
						end
						3'd1: begin
							nx.clk_level = 1'b1;
							nx.step = 3'd2;
						end
						3'd2: begin
							nx.shift = rx_shift;
							if (st_q.bit_pos == 3'd7) begin
								result.byte_valid = 1'b1;
								result.read_byte  = rx_shift;
							end
							nx.step = 3'd3;
						end
						3'd3: begin
							nx.clk_level = 1'b0;
							if (st_q.bit_pos == 3'd7) begin
								nx.step = 3'd4;
							end else begin
								nx.bit_pos = st_q.bit_pos + 3'd1;
								nx.step = 3'd1;
							end
						end
						3'd4: begin
							// ack every byte but the last
							nx.dat_level = (st_q.remaining > 8'd1) ? 1'b0 : 1'b1;
							nx.step = 3'd5;
						end
						3'd5: begin
							nx.clk_level = 1'b1;
							nx.step = 3'd6;
						end
						3'd6: begin
							nx.clk_level = 1'b0;
							nx.step      = '0;
							nx.bit_pos   = '0;
							nx.remaining = st_q.remaining - 8'd1;
							nx.phase = (st_q.remaining == 8'd1) ? PH_STOP : PH_R_READ;
						end
						default: begin
							nx.step = '0;
						end
					endcase
				end
				PH_STOP: begin
					if (st_q.step == 3'd0) begin
						nx.dat_level = 1'b0;
						nx.step = 3'd1;
					end else if (st_q.step == 3'd1) begin
						nx.clk_level = 1'b1;
						nx.step = 3'd2;
					end else begin
						nx.dat_level = 1'b1;
						result.done_res = 1'b1;
						result.success  = st_q.acked;
						nx.phase   = PH_IDLE;
						nx.step    = '0;
						nx.bit_pos = '0;
					end
				end
				default: begin
					nx.phase   = PH_IDLE;
					nx.step    = '0;
					nx.bit_pos = '0;
				end
			endcase
		end

		result.scl_out = nx.clk_level;
		result.sda_out = nx.dat_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, step: '0, bit_pos: '0, shift: '0, remaining: '0,
				held_reg: '0, held_val: '0, clk_level: 1'b1, dat_level: 1'b1, acked: 1'b0};
			dev_addr_q <= DEV_ADDR_RESET;
		end else begin
			if (step_en) begin
				st_q <= nx;
			end
			if (cfg_wr_en) begin
				dev_addr_q <= cfg_wr_data;
			end
		end
	end

endmodule

// ===== src/i2c_register_access_master_core.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master_core
// i2c master for register writes and burst reads, one pin action per word
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  input   | in_valid / in_stall    | op, reg_addr, write_value, read_length, sda_in
//  output  | out_valid / out_stall  | scl_out, sda_out, busy_res, byte_valid,
//          |                        | read_byte, done_res, success
//  config  | cfg_wr_en              | cfg_wr_data (device address)
//
// one word per cycle sustained while out_stall is low; a word passes the input register, then
// the sequencer step into the output register
// reset puts the sequencer idle, both lines released, device address 104
// a stalled output holds its word; the input register still drains into the
// output register whenever that register is empty or being taken
module i2c_register_access_master_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [i2cram_pkg::DevAddrW-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [7:0]                      reg_addr,
	input  logic [7:0]                      write_value,
	input  logic [7:0]                      read_length,
	input  logic                            sda_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            scl_out,
	output logic                            sda_out,
	output logic                            busy_res,
	output logic                            byte_valid,
	output logic [7:0]                      read_byte,
	output logic                            done_res,
	output logic                            success
);
	import i2cram_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{op: op, reg_addr: reg_addr, write_value: write_value,
				read_length: read_length, sda_in: sda_in};
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	i2cram_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (advance),
		.item        (item_s1),
		.result      (res_comb)
	);

	assign out_valid  = valid_s2;
	assign scl_out    = res_s2.scl_out;
	assign sda_out    = res_s2.sda_out;
	assign busy_res   = res_s2.busy_res;
	assign byte_valid = res_s2.byte_valid;
	assign read_byte  = res_s2.read_byte;
	assign done_res   = res_s2.done_res;
	assign success    = res_s2.success;

endmodule
